/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SBA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sba assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sba assertion failed");

`endif

/* design/sba_pkg.sv */
package sba_pkg;

   localparam int DISPLAY_COLUMNS   = 32;
   localparam int MAX_SPECTRUM_BINS = 1024;
   localparam int MAX_BIN_WIDTH     = 36;
   localparam int MAGNITUDE_BITS    = 20;

   localparam int FIRST_BIN_W  = $clog2(MAX_SPECTRUM_BINS);
   localparam int BIN_CNT_W    = FIRST_BIN_W + 1;
   localparam int BIN_WIDTH_W  = 6;
   localparam int FOLD_MODE_W  = 2;
   localparam int CSR_DATA_W   = 10;
   localparam int CSR_INDEX_W  = 2;
   localparam int ACC_W        = MAGNITUDE_BITS + $clog2(MAX_BIN_WIDTH);
   localparam int VALUE_W      = 16;
   localparam int COL_W        = 5;
   localparam int CNT_W        = $clog2(DISPLAY_COLUMNS + 1);
   localparam int DIV_CNT_W    = $clog2(ACC_W);
   localparam int JOB_DEPTH    = 4;
   localparam int JOB_PTR_W    = $clog2(JOB_DEPTH);

   localparam logic [BIN_CNT_W-1:0] BIN_CNT_MAX = {BIN_CNT_W{1'b1}};
   localparam logic [VALUE_W-1:0]   VALUE_SAT   = {VALUE_W{1'b1}};
   localparam logic [CNT_W-1:0]     LAST_COL    = CNT_W'(DISPLAY_COLUMNS - 1);

   typedef enum logic [FOLD_MODE_W-1:0] {
      FOLD_SUM  = 2'd0,
      FOLD_MAX  = 2'd1,
      FOLD_AVG  = 2'd2,
      FOLD_NONE = 2'd3
   } fold_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_BIN = 2'd0,
      CSR_BIN_WIDTH = 2'd1,
      CSR_FOLD_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FIRST_BIN_W-1:0] first_bin;
      logic [BIN_WIDTH_W-1:0] bin_width;
      fold_type               fold_mode;
   } cfg_type;

   // one unit of work for the back end: a finished column and/or the empty tail
   typedef struct packed {
      logic                   has_column;
      logic                   fill;
      logic [CNT_W-1:0]       col;
      logic [ACC_W-1:0]       acc;
      logic [BIN_WIDTH_W-1:0] width;
      fold_type               mode;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_COLUMN,
      ST_FILL
   } back_state_type;

endpackage

/* design/sba_front.sv */
module sba_front
   import sba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      push,
   output logic                      full,
   input  logic [MAGNITUDE_BITS-1:0] req_magnitude,
   input  logic                      req_frame_end,
   input  logic                      job_full,
   output logic                      job_push,
   output job_type                   job_wdata
);

   logic [BIN_CNT_W-1:0]   bin_cnt_ff, bin_cnt_in;
   logic [BIN_WIDTH_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0]       cols_ff, cols_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;

   logic                   accept;
   logic [BIN_WIDTH_W-1:0] width;
   logic                   in_window;
   logic [ACC_W-1:0]       mag_ext;
   logic [ACC_W-1:0]       acc_next;
   logic [BIN_WIDTH_W-1:0] run_next;
   logic                   col_done;
   logic [CNT_W-1:0]       cols_after;
   logic                   fill;

   assign accept = push && !job_full;
   assign full   = job_full;

   always_comb begin
      if (cfg.bin_width == '0) begin
         width = BIN_WIDTH_W'(1);
      end else if (cfg.bin_width > BIN_WIDTH_W'(MAX_BIN_WIDTH)) begin
         width = BIN_WIDTH_W'(MAX_BIN_WIDTH);
      end else begin
         width = cfg.bin_width;
      end
   end

   assign in_window = (bin_cnt_ff >= BIN_CNT_W'(cfg.first_bin))
                   && (cols_ff < CNT_W'(DISPLAY_COLUMNS));
   assign mag_ext   = ACC_W'(req_magnitude);

   always_comb begin
      if (cfg.fold_mode == FOLD_MAX) begin
         acc_next = (mag_ext > acc_ff) ? mag_ext : acc_ff;
      end else begin
         acc_next = acc_ff + mag_ext;
      end
   end

   assign run_next   = run_ff + BIN_WIDTH_W'(1);
   assign col_done   = in_window && (run_next >= width);
   assign cols_after = cols_ff + CNT_W'(col_done);
   // the empty tail only exists when the display is not yet full
   assign fill       = req_frame_end && (cols_after < CNT_W'(DISPLAY_COLUMNS));

   assign job_push             = accept && (col_done || fill);
   assign job_wdata.has_column = col_done;
   assign job_wdata.fill       = fill;
   assign job_wdata.col        = cols_ff;
   assign job_wdata.acc        = acc_next;
   assign job_wdata.width      = width;
   assign job_wdata.mode       = cfg.fold_mode;

   always_comb begin
      bin_cnt_in = bin_cnt_ff;
      run_in     = run_ff;
      cols_in    = cols_ff;
      acc_in     = acc_ff;
      if (accept) begin
         if (req_frame_end) begin
            bin_cnt_in = '0;
            run_in     = '0;
            cols_in    = '0;
            acc_in     = '0;
         end else begin
            if (bin_cnt_ff != BIN_CNT_MAX) begin
               bin_cnt_in = bin_cnt_ff + BIN_CNT_W'(1);
            end
            if (in_window) begin
               cols_in = cols_after;
               if (col_done) begin
                  run_in = '0;
                  acc_in = '0;
               end else begin
                  run_in = run_next;
                  acc_in = acc_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff <= '0;
         run_ff     <= '0;
         cols_ff    <= '0;
         acc_ff     <= '0;
      end else begin
         bin_cnt_ff <= bin_cnt_in;
         run_ff     <= run_in;
         cols_ff    <= cols_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

/* design/sba_job_fifo.sv */
module sba_job_fifo
   import sba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wdata,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type rdata
);

   job_type              mem [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_PTR_W:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == (JOB_PTR_W + 1)'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (JOB_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (JOB_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/sba_back.sv */
`include "assert_macros.svh"

module sba_back
   import sba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  job_type            job_rdata,
   output logic               job_pop,
   output logic               empty,
   input  logic               pop,
   output logic [COL_W-1:0]   rsp_column_index,
   output logic [VALUE_W-1:0] rsp_column_value,
   output logic               rsp_column_empty,
   output logic               rsp_last_column
);

   back_state_type state_ff, state_in;

   logic                   fill_ff, fill_in;
   fold_type               mode_ff, mode_in;
   logic [BIN_WIDTH_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0]       col_ff, col_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [BIN_WIDTH_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   logic                   rsp_valid_ff;
   logic [COL_W-1:0]       rsp_index_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   out_load;
   logic [VALUE_W-1:0]     out_value;
   logic                   out_empty;
   logic                   div_last;
   logic [BIN_WIDTH_W:0]   trial;
   logic                   q_bit;
   logic                   fill_load;
   logic                   last_load;

   assign out_free = !rsp_valid_ff || pop;
   assign div_last = (div_cnt_ff == DIV_CNT_W'(ACC_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               if (!job_rdata.has_column) begin
                  state_in = ST_FILL;
               end else if (job_rdata.mode == FOLD_AVG) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_COLUMN;
               end
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_COLUMN;
            end
         end
         ST_COLUMN: begin
            if (out_free) begin
               state_in = fill_ff ? ST_FILL : ST_IDLE;
            end
         end
         ST_FILL: begin
            if (out_free && (col_ff == LAST_COL)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      job_pop   = 1'b0;
      out_load  = 1'b0;
      out_value = '0;
      out_empty = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            job_pop = !job_empty;
         end
         ST_DIV: begin
            job_pop = 1'b0;
         end
         ST_COLUMN: begin
            out_load = out_free;
            if (mode_ff == FOLD_NONE) begin
               out_value = '0;
            end else if (acc_ff > ACC_W'(VALUE_SAT)) begin
               out_value = VALUE_SAT;
            end else begin
               out_value = acc_ff[VALUE_W-1:0];
            end
         end
         ST_FILL: begin
            out_load  = out_free;
            out_empty = 1'b1;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // restoring divider, one quotient bit per cycle, quotient shifts into acc
   assign trial = {rem_ff, acc_ff[ACC_W-1]};
   assign q_bit = (trial >= {1'b0, width_ff});

   always_comb begin
      fill_in    = fill_ff;
      mode_in    = mode_ff;
      width_in   = width_ff;
      col_in     = col_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (job_pop) begin
         fill_in    = job_rdata.fill;
         mode_in    = job_rdata.mode;
         width_in   = job_rdata.width;
         col_in     = job_rdata.col;
         acc_in     = job_rdata.acc;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         rem_in     = q_bit ? BIN_WIDTH_W'(trial - {1'b0, width_ff})
                            : trial[BIN_WIDTH_W-1:0];
         acc_in     = {acc_ff[ACC_W-2:0], q_bit};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end else if (out_load) begin
         col_in = col_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      mode_ff    <= mode_in;
      width_ff   <= width_in;
      col_ff     <= col_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // result register, parts the sequencer from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_index_ff <= col_ff[COL_W-1:0];
         rsp_value_ff <= out_value;
         rsp_empty_ff <= out_empty;
         rsp_last_ff  <= (col_ff == LAST_COL);
      end
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_column_index = rsp_index_ff;
   assign rsp_column_value = rsp_value_ff;
   assign rsp_column_empty = rsp_empty_ff;
   assign rsp_last_column  = rsp_last_ff;

   assign fill_load = (state_ff == ST_FILL) && out_load;
   assign last_load = out_load && (col_ff == LAST_COL);

   `SBA_ASSERT_NEXT(a_fill_is_empty_zero, fill_load, rsp_empty_ff && (rsp_value_ff == '0))
   `SBA_ASSERT_NEXT(a_last_col_ends_frame, last_load, (state_ff == ST_IDLE) && rsp_last_ff)
   `SBA_ASSERT_NEXT(a_div_then_column, (state_ff == ST_DIV) && div_last, state_ff == ST_COLUMN)

endmodule

/* design/spectrum_band_aggregator.sv */
// path: a finished column goes through the job queue, the back-end job registers and the result
// register; the floor average adds the bit-serial divider (ST_DIV) before the result register
// throughput: one magnitude per cycle until the 4-entry job queue fills; the back end finishes
// each job, its column and any empty columns at frame end, before it pops the next one
// reset: synchronous, active high; registers return to first_bin 0, bin_width 8, fold_mode 2,
// frame counters clear and both queues empty
module spectrum_band_aggregator
   import sba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [MAGNITUDE_BITS-1:0] req_magnitude,
   input  logic                      req_frame_end,
   output logic                      empty,
   input  logic                      pop,
   output logic [COL_W-1:0]          rsp_column_index,
   output logic [VALUE_W-1:0]        rsp_column_value,
   output logic                      rsp_column_empty,
   output logic                      rsp_last_column,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;
   job_type job_wdata;
   job_type job_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_FIRST_BIN: cfg_in.first_bin = csr_wdata[FIRST_BIN_W-1:0];
            CSR_BIN_WIDTH: cfg_in.bin_width = csr_wdata[BIN_WIDTH_W-1:0];
            CSR_FOLD_MODE: cfg_in.fold_mode = fold_type'(csr_wdata[FOLD_MODE_W-1:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bin <= '0;
         cfg_ff.bin_width <= BIN_WIDTH_W'(8);
         cfg_ff.fold_mode <= FOLD_AVG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sba_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .push          (push),
      .full          (full),
      .req_magnitude (req_magnitude),
      .req_frame_end (req_frame_end),
      .job_full      (job_full),
      .job_push      (job_push),
      .job_wdata     (job_wdata)
   );

   sba_job_fifo u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job_rdata)
   );

   sba_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (job_empty),
      .job_rdata        (job_rdata),
      .job_pop          (job_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_column_index (rsp_column_index),
      .rsp_column_value (rsp_column_value),
      .rsp_column_empty (rsp_column_empty),
      .rsp_last_column  (rsp_last_column)
   );

endmodule
